@@ rtl/rsbk_pkg.sv @@
// ----------------------------------------------------------------------------
// rsbk_pkg
// shared types and constants for the record sort unit
// ----------------------------------------------------------------------------
package rsbk_pkg;

  localparam int DEPTH     = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 6;
  localparam int ID_W      = 16;
  localparam int RCP_W     = 27;

  // one delivery record as held in a cell
  typedef struct packed {
    logic [ID_W-1:0]  guide_id;
    logic [RCP_W-1:0] recipient_id;
    logic [ID_W-1:0]  origin_city;
    logic [ID_W-1:0]  dest_city;
    logic [ID_W-1:0]  vehicle_id;
  } rec_t;

  // chain control, same for every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // emission beat from the sequencer
  typedef struct packed {
    logic beat;
    logic last;
  } emit_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/rsbk_cell.sv @@
// ----------------------------------------------------------------------------
// rsbk_cell
// one slot of the insertion chain
// ----------------------------------------------------------------------------
module rsbk_cell (
  input  logic                clk,
  input  logic                rst,
  input  rsbk_pkg::cell_ctrl_t ctrl,
  input  rsbk_pkg::rec_t      new_rec,
  input  logic                prev_valid,
  input  logic                prev_gt,
  input  rsbk_pkg::rec_t      prev_rec,
  input  logic                next_valid,
  input  rsbk_pkg::rec_t      next_rec,
  output logic                valid,
  output logic                gt,
  output rsbk_pkg::rec_t      rec
);
  import rsbk_pkg::*;

  logic take_prev;
  logic take_new;

  // strictly greater, so equal keys stay ahead of the newcomer
  assign gt        = valid && (rec.vehicle_id > new_rec.vehicle_id);
  assign take_prev = ctrl.insert && prev_gt;
  assign take_new  = ctrl.insert && !prev_gt && (gt || (!valid && prev_valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (take_prev || take_new) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      rec <= next_rec;
    end else if (take_prev) begin
      rec <= prev_rec;
    end else if (take_new) begin
      rec <= new_rec;
    end
  end

endmodule

@@ rtl/rsbk_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsbk_ctrl
// load / emit sequencer with record counters
// ----------------------------------------------------------------------------
module rsbk_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         last_in,
  input  logic                         same_city,
  input  logic                         head_valid,
  input  logic                         second_valid,
  output logic                         busy,
  output rsbk_pkg::cell_ctrl_t         ctrl,
  output rsbk_pkg::emit_t              emit,
  output logic [rsbk_pkg::CNT_W-1:0]   fill,
  output logic [rsbk_pkg::CNT_W-1:0]   match,
  output logic                         dropped
);
  import rsbk_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] match_next;
  logic             dropped_next;
  logic             accept;
  logic             full;

  // busy is low exactly while loading
  assign full   = (fill == CNT_W'(DEPTH));
  assign accept = start && (state == ST_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      fill    <= '0;
      match   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      match   <= match_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    match_next   = match;
    dropped_next = dropped;
    busy         = 1'b0;
    ctrl         = '0;
    emit         = '0;
    case (state)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            fill_next   = fill + CNT_W'(1);
            if (same_city) begin
              match_next = match + CNT_W'(1);
            end
          end
          if (last_in) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        busy       = 1'b1;
        ctrl.shift = 1'b1;
        emit.beat  = head_valid;
        emit.last  = head_valid && !second_valid;
        if (!head_valid || !second_valid) begin
          state_next   = ST_LOAD;
          fill_next    = '0;
          match_next   = '0;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/record_sort_by_key_with_counts_unit.sv @@
// ----------------------------------------------------------------------------
// record_sort_by_key_with_counts_unit
// stable sort of delivery records by vehicle id, with counts
// ----------------------------------------------------------------------------
// records are taken one per cycle while busy is low: a beat is start high at
// a rising edge with busy low. every record lands in its sorted place in the
// same cycle, since each cell of the chain compares its key against the new
// one in parallel and moves up by one if it is larger. the record flagged
// last_in ends the load; busy then stays high until every held record (one to
// DEPTH) has been emitted, the chain shifting one record toward the head each
// cycle, and each sorted record shows on the result ports in the next cycle for
// exactly one cycle with strobe high. the receiver cannot hold results off.
// records beyond DEPTH are dropped and flag overflow; the counts and the
// overflow flag repeat on every result of the run.
module record_sort_by_key_with_counts_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] guide_id,
  input  logic [26:0] recipient_id,
  input  logic [15:0] origin_city,
  input  logic [15:0] dest_city,
  input  logic [15:0] vehicle_id,
  input  logic        last_in,
  output logic        strobe,
  output logic [15:0] out_guide_id,
  output logic [26:0] out_recipient_id,
  output logic [15:0] out_origin_city,
  output logic [15:0] out_dest_city,
  output logic [15:0] out_vehicle_id,
  output logic        last_out,
  output logic [5:0]  total_count,
  output logic [5:0]  same_city_count,
  output logic        overflow
);
  import rsbk_pkg::*;

  rec_t             new_rec;
  cell_ctrl_t       ctrl;
  emit_t            emit;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] match;
  logic             dropped;

  // chain taps, index 0 is the head (smallest key)
  logic             cell_valid [DEPTH];
  logic             cell_gt    [DEPTH];
  rec_t             cell_rec   [DEPTH];

  assign new_rec.guide_id     = guide_id;
  assign new_rec.recipient_id = recipient_id;
  assign new_rec.origin_city  = origin_city;
  assign new_rec.dest_city    = dest_city;
  assign new_rec.vehicle_id   = vehicle_id;

  rsbk_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_in      (last_in),
    .same_city    (origin_city == dest_city),
    .head_valid   (cell_valid[0]),
    .second_valid (cell_valid[1]),
    .busy         (busy),
    .ctrl         (ctrl),
    .emit         (emit),
    .fill         (fill),
    .match        (match),
    .dropped      (dropped)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic prev_valid;
    logic prev_gt;
    rec_t prev_rec;
    logic next_valid;
    rec_t next_rec;

    // head cell sees an always-full, never-larger neighbor below it
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
      assign prev_rec   = '0;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
      assign prev_rec   = cell_rec[i-1];
    end

    // tail cell pulls in an empty slot on emission
    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_rec   = '0;
    end else begin : g_body
      assign next_valid = cell_valid[i+1];
      assign next_rec   = cell_rec[i+1];
    end

    rsbk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_rec    (new_rec),
      .prev_valid (prev_valid),
      .prev_gt    (prev_gt),
      .prev_rec   (prev_rec),
      .next_valid (next_valid),
      .next_rec   (next_rec),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i]),
      .rec        (cell_rec[i])
    );
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit.beat;
    end
  end

  // payload, counts are truncated to the port width
  always_ff @(posedge clk) begin
    if (emit.beat) begin
      out_guide_id     <= cell_rec[0].guide_id;
      out_recipient_id <= cell_rec[0].recipient_id;
      out_origin_city  <= cell_rec[0].origin_city;
      out_dest_city    <= cell_rec[0].dest_city;
      out_vehicle_id   <= cell_rec[0].vehicle_id;
      last_out         <= emit.last;
      total_count      <= OUT_CNT_W'(fill);
      same_city_count  <= OUT_CNT_W'(match);
      overflow         <= dropped;
    end
  end

endmodule

@@ rtl/rsbk_checker.sv @@
// ----------------------------------------------------------------------------
// rsbk_checker
// port-level checks for the record sort unit
// ----------------------------------------------------------------------------
module rsbk_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        strobe,
  input logic [15:0] out_vehicle_id,
  input logic        last_out,
  input logic [5:0]  total_count,
  input logic [5:0]  same_city_count,
  input logic        overflow
);

  // a result beat only follows an emitting cycle
  a_beat_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result beat without emission");

  // beats of one run are back to back
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_out |=> strobe)
    else $error("gap inside result run");

  // run ends cleanly after the final beat
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_out |=> !strobe)
    else $error("beat after final result");

  // keys ascend within a run
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_out |=> out_vehicle_id >= $past(out_vehicle_id))
    else $error("vehicle ids out of order");

  // counts and overflow hold across a run
  a_counts_steady: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_out |=> $stable(total_count) && $stable(same_city_count)
      && $stable(overflow))
    else $error("counts changed inside run");

endmodule

bind record_sort_by_key_with_counts_unit rsbk_checker u_rsbk_checker (.*);
